FILE: rtl/ternary_hadamard_transform_mod_p_assert.svh
// Assertion macros shared by the ternary Hadamard transform RTL.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef TERNARY_HADAMARD_TRANSFORM_MOD_P_ASSERT_SVH
`define TERNARY_HADAMARD_TRANSFORM_MOD_P_ASSERT_SVH

// Same-cycle implication, off during reset.
`define THMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define THMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/thmp_pkg.sv
// Package for the ternary Hadamard transform: sizes, prime, codes,
// controller/datapath command types and small helper functions. No dependencies.
package thmp_pkg;

    localparam int TRITS = 8;
    localparam int DEPTH = 3 ** TRITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = 30;
    localparam int CW    = $clog2(DW);

    localparam logic [DW-1:0] PRIME    = 30'd1000000009;
    localparam logic [DW+1:0] PRIME_X2 = {1'b0, PRIME, 1'b0};

    localparam logic [DW-1:0] ROOT_ONE_RST  = 30'd115381398;
    localparam logic [DW-1:0] ROOT_TWO_RST  = 30'd884618610;
    localparam logic [DW-1:0] INV_THREE_RST = 30'd666666673;
    localparam logic [3:0]    TRITS_RST     = 4'd8;

    typedef logic [AW-1:0] t_addr;
    typedef logic [DW-1:0] t_word;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_INVERSE   = 3'd0,
        CFG_TRITS     = 3'd1,
        CFG_ROOT_ONE  = 3'd2,
        CFG_ROOT_TWO  = 3'd3,
        CFG_INV_THREE = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOP,
        ST_RA,
        ST_RB,
        ST_RC,
        ST_CAPC,
        ST_SUM,
        ST_MSTART,
        ST_MWAIT,
        ST_WA,
        ST_WB,
        ST_WC
    } t_state;

    // Products of one butterfly, in issue order.
    typedef enum logic [2:0] {
        MOP_B_WF,
        MOP_C_WS,
        MOP_B_WS,
        MOP_C_WF,
        MOP_X_I3,
        MOP_Y_I3,
        MOP_Z_I3
    } t_mop;

    typedef enum logic [1:0] {
        WS_INPUT,
        WS_X,
        WS_Y,
        WS_Z
    } t_wsel;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_A,
        CAP_B,
        CAP_C
    } t_cap;

    typedef struct packed {
        t_addr addr;
        logic  mem_we;
        logic  mem_re;
        t_wsel wsel;
        t_cap  cap;
        logic  sum;
        logic  mul_start;
        t_mop  mop;
        logic  out_load;
        logic  out_from_mem;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
    } t_dp_status;

    // Values below 2^30 are below twice the prime: one subtract reduces.
    function automatic t_word mod_reduce(input t_word v);
        return (v >= PRIME) ? t_word'(v - PRIME) : v;
    endfunction

    // 3^t, saturating t at TRITS.
    function automatic t_addr pow3(input logic [3:0] t);
        t_addr r;
        r = t_addr'(1);
        for (int i = 0; i < TRITS; i++) begin
            if (4'(i) < t) begin
                r = t_addr'(r * 3);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/thmp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on thmp_pkg; operands must be reduced below the prime.
`include "ternary_hadamard_transform_mod_p_assert.svh"

module thmp_mulmod import thmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_op_a,
    input  t_word i_op_b,
    output logic  o_done,
    output t_word o_result
);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CW-1:0]  r_cnt, n_cnt;
    t_word          r_acc, n_acc;
    t_word          r_x, n_x;
    t_word          r_m, n_m;
    logic [DW+1:0]  step_sum;
    t_word          step_red;

    always_comb begin
        step_sum = {1'b0, r_acc, 1'b0} + (r_m[DW-1] ? {2'b00, r_x} : '0);
        if (step_sum >= PRIME_X2) begin
            step_red = t_word'(step_sum - PRIME_X2);
        end else if (step_sum >= {2'b00, PRIME}) begin
            step_red = t_word'(step_sum - {2'b00, PRIME});
        end else begin
            step_red = t_word'(step_sum);
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_m    = r_m;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_x    = i_op_a;
            n_m    = i_op_b;
        end else if (r_busy) begin
            n_acc = step_red;
            n_m   = {r_m[DW-2:0], 1'b0};
            n_cnt = CW'(r_cnt + 1'b1);
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_m   <= n_m;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    `THMP_ASSERT_IMP(a_start_idle, i_start, !r_busy, "multiplier started while busy")
    `THMP_ASSERT_IMP(a_result_reduced, r_done, r_acc < PRIME, "product not reduced")
    `THMP_ASSERT_NXT(a_done_ends_busy, r_done, !r_busy || i_start == 1'b0, "busy after done")

endmodule

FILE: rtl/thmp_ctrl.sv
// Controller: item handshake, butterfly loop counters and sequencing.
// Depends on thmp_pkg; drives thmp_datapath through t_dp_cmd.
`include "ternary_hadamard_transform_mod_p_assert.svh"

module thmp_ctrl import thmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  t_addr      i_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic       i_inverse,
    input  logic [3:0] i_trits,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state          r_state, n_state;
    logic            r_out_valid, n_out_valid;
    t_addr           r_span, n_span;
    logic [AW+1:0]   r_span3, n_span3;
    t_addr           r_base, n_base;
    t_addr           r_k, n_k;
    t_addr           r_n, n_n;
    t_mop            r_mop, n_mop;

    logic            accept;
    logic            in_range;
    t_addr           addr_a, addr_b, addr_c;
    t_mop            last_mop;
    logic [AW+1:0]   next_base;

    function automatic t_mop next_mop(input t_mop m);
        t_mop r;
        unique case (m)
            MOP_B_WF: r = MOP_C_WS;
            MOP_C_WS: r = MOP_B_WS;
            MOP_B_WS: r = MOP_C_WF;
            MOP_C_WF: r = MOP_X_I3;
            MOP_X_I3: r = MOP_Y_I3;
            MOP_Y_I3: r = MOP_Z_I3;
            default:  r = MOP_B_WF;
        endcase
        return r;
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign in_range    = (i_index < t_addr'(DEPTH));
    assign o_out_valid = r_out_valid;
    assign addr_a      = t_addr'(r_base + r_k);
    assign addr_b      = t_addr'(addr_a + r_span);
    assign addr_c      = t_addr'(addr_b + r_span);
    assign last_mop    = i_inverse ? MOP_Z_I3 : MOP_C_WF;
    assign next_base   = {2'b00, r_base} + r_span3;

    always_comb begin
        n_state = r_state;
        n_span  = r_span;
        n_span3 = r_span3;
        n_base  = r_base;
        n_k     = r_k;
        n_n     = r_n;
        n_mop   = r_mop;
        o_cmd              = '0;
        o_cmd.addr         = i_index;
        o_cmd.mop          = r_mop;
        o_cmd.wsel         = WS_INPUT;
        o_cmd.cap          = CAP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_WRITE: begin
                            o_cmd.mem_we   = in_range;
                            o_cmd.out_load = 1'b1;
                        end
                        OP_READ: begin
                            o_cmd.mem_re = in_range;
                            if (in_range) begin
                                n_state = ST_READ;
                            end else begin
                                o_cmd.out_load = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            n_span  = t_addr'(1);
                            n_span3 = (AW+2)'(3);
                            n_base  = '0;
                            n_k     = '0;
                            n_n     = pow3(i_trits);
                            n_state = ST_LOOP;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.out_load     = 1'b1;
                o_cmd.out_from_mem = 1'b1;
                n_state            = ST_IDLE;
            end
            ST_LOOP: begin
                if (r_span3 > {2'b00, r_n}) begin
                    // all levels done: answer the run item
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_RA;
                end
            end
            ST_RA: begin
                o_cmd.addr   = addr_a;
                o_cmd.mem_re = 1'b1;
                n_state      = ST_RB;
            end
            ST_RB: begin
                o_cmd.addr   = addr_b;
                o_cmd.mem_re = 1'b1;
                o_cmd.cap    = CAP_A;
                n_state      = ST_RC;
            end
            ST_RC: begin
                o_cmd.addr   = addr_c;
                o_cmd.mem_re = 1'b1;
                o_cmd.cap    = CAP_B;
                n_state      = ST_CAPC;
            end
            ST_CAPC: begin
                o_cmd.cap = CAP_C;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_mop     = MOP_B_WF;
                n_state   = ST_MSTART;
            end
            ST_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_status.mul_done) begin
                    if (r_mop == last_mop) begin
                        n_state = ST_WA;
                    end else begin
                        n_mop   = next_mop(r_mop);
                        n_state = ST_MSTART;
                    end
                end
            end
            ST_WA: begin
                o_cmd.addr   = addr_a;
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_X;
                n_state      = ST_WB;
            end
            ST_WB: begin
                o_cmd.addr   = addr_b;
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_Y;
                n_state      = ST_WC;
            end
            ST_WC: begin
                o_cmd.addr   = addr_c;
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_Z;
                n_state      = ST_LOOP;
                // advance k, then base, then span
                if ({1'b0, r_k} + 1'b1 < {1'b0, r_span}) begin
                    n_k = t_addr'(r_k + 1'b1);
                end else begin
                    n_k = '0;
                    if (next_base < {2'b00, r_n}) begin
                        n_base = t_addr'(next_base);
                    end else begin
                        n_base  = '0;
                        n_span  = t_addr'(r_span3);
                        n_span3 = (AW+2)'(r_span3 * 3);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mop       <= MOP_B_WF;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mop       <= n_mop;
        end
        r_span  <= n_span;
        r_span3 <= n_span3;
        r_base  <= n_base;
        r_k     <= n_k;
        r_n     <= n_n;
    end

    `THMP_ASSERT_IMP(a_done_in_wait, i_status.mul_done, r_state == ST_MWAIT, "stray product")
    `THMP_ASSERT_IMP(a_busy_no_result, r_state != ST_IDLE, !r_out_valid, "result held while busy")
    `THMP_ASSERT_IMP(a_load_free, o_cmd.out_load, !r_out_valid || i_out_ready, "result overrun")
    `THMP_ASSERT_NXT(a_accept_leaves, accept && (i_opcode == OP_RUN), r_state == ST_LOOP,
                     "run not started")

endmodule

FILE: rtl/thmp_datapath.sv
// Datapath: vector memory, butterfly operand registers, modular adders
// and the shared bit-serial multiplier. Depends on thmp_pkg and thmp_mulmod.
module thmp_datapath import thmp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_word      i_value,
    input  logic       i_inverse,
    input  t_word      i_root_one,
    input  t_word      i_root_two,
    input  t_word      i_inv_three,
    output t_word      o_data
);

    t_word          mem [DEPTH];
    t_word          r_rd_data;
    t_word          r_a, r_b, r_c;
    t_word          r_x, r_y, r_z;
    t_word          r_out_data;

    t_word          w_first, w_second, inv3;
    t_word          mul_a, mul_b, mul_res;
    logic           mul_done;
    t_word          wdata;
    logic [DW+1:0]  sum3;
    t_word          sum3_red;
    t_word          acc_src;
    logic [DW:0]    acc_sum;
    t_word          acc_red;

    assign w_first  = mod_reduce(i_inverse ? i_root_two : i_root_one);
    assign w_second = mod_reduce(i_inverse ? i_root_one : i_root_two);
    assign inv3     = mod_reduce(i_inv_three);

    always_comb begin
        case (i_cmd.mop)
            MOP_B_WF: begin mul_a = r_b; mul_b = w_first;  end
            MOP_C_WS: begin mul_a = r_c; mul_b = w_second; end
            MOP_B_WS: begin mul_a = r_b; mul_b = w_second; end
            MOP_C_WF: begin mul_a = r_c; mul_b = w_first;  end
            MOP_X_I3: begin mul_a = r_x; mul_b = inv3;     end
            MOP_Y_I3: begin mul_a = r_y; mul_b = inv3;     end
            default:  begin mul_a = r_z; mul_b = inv3;     end
        endcase
    end

    thmp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_op_a   (mul_a),
        .i_op_b   (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign o_status.mul_done = mul_done;

    always_comb begin
        sum3 = {2'b00, r_a} + {2'b00, r_b} + {2'b00, r_c};
        if (sum3 >= PRIME_X2) begin
            sum3_red = t_word'(sum3 - PRIME_X2);
        end else if (sum3 >= {2'b00, PRIME}) begin
            sum3_red = t_word'(sum3 - {2'b00, PRIME});
        end else begin
            sum3_red = t_word'(sum3);
        end
    end

    // products of b go with y for the first pair, z for the second
    assign acc_src = (i_cmd.mop == MOP_B_WF || i_cmd.mop == MOP_C_WS) ? r_y : r_z;
    assign acc_sum = {1'b0, acc_src} + {1'b0, mul_res};
    assign acc_red = (acc_sum >= {1'b0, PRIME}) ? t_word'(acc_sum - {1'b0, PRIME})
                                                : t_word'(acc_sum);

    always_comb begin
        case (i_cmd.wsel)
            WS_INPUT: wdata = i_value;
            WS_X:     wdata = r_x;
            WS_Y:     wdata = r_y;
            default:  wdata = r_z;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[i_cmd.addr] <= wdata;
        end
        if (i_cmd.mem_re) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            CAP_A:   r_a <= mod_reduce(r_rd_data);
            CAP_B:   r_b <= mod_reduce(r_rd_data);
            CAP_C:   r_c <= mod_reduce(r_rd_data);
            default: ;
        endcase
        if (i_cmd.sum) begin
            r_x <= sum3_red;
            r_y <= r_a;
            r_z <= r_a;
        end else if (mul_done) begin
            case (i_cmd.mop) inside
                MOP_B_WF, MOP_C_WS: r_y <= acc_red;
                MOP_B_WS, MOP_C_WF: r_z <= acc_red;
                MOP_X_I3:           r_x <= mul_res;
                MOP_Y_I3:           r_y <= mul_res;
                default:            r_z <= mul_res;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_data <= i_cmd.out_from_mem ? r_rd_data : '0;
        end
    end

    assign o_data = r_out_data;

endmodule

FILE: rtl/ternary_hadamard_transform_mod_p.sv
// Ternary (radix-3) Hadamard transform modulo 1000000009 over a 6561-entry
// vector. A run item is paced by the shared bit-serial modular multiplier
// (one bit per cycle, four products per butterfly forward and seven inverse)
// and the single memory port (three reads, three writes per butterfly).
// Every result, including the one for a run, is given once the item's work ends.
module ternary_hadamard_transform_mod_p import thmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [12:0] i_index,
    input  logic [29:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [29:0] o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);

    logic       r_inverse;
    logic [3:0] r_trits;
    t_word      r_root_one, r_root_two, r_inv_three;
    t_dp_cmd    cmd;
    t_dp_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse   <= 1'b0;
            r_trits     <= TRITS_RST;
            r_root_one  <= ROOT_ONE_RST;
            r_root_two  <= ROOT_TWO_RST;
            r_inv_three <= INV_THREE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INVERSE:   r_inverse   <= i_cfg_data[0];
                CFG_TRITS:     r_trits     <= i_cfg_data[3:0];
                CFG_ROOT_ONE:  r_root_one  <= i_cfg_data;
                CFG_ROOT_TWO:  r_root_two  <= i_cfg_data;
                CFG_INV_THREE: r_inv_three <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    thmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_inverse   (r_inverse),
        .i_trits     (r_trits),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    thmp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_value),
        .i_inverse   (r_inverse),
        .i_root_one  (r_root_one),
        .i_root_two  (r_root_two),
        .i_inv_three (r_inv_three),
        .o_data      (o_data)
    );

endmodule
